// File: design/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the bitmap fit allocator: pool geometry, field widths,
// opcodes, status codes and register indexes. No dependencies.
package bfa_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int BLOCK_BYTES = 4;
    localparam int BB_SHIFT    = $clog2(BLOCK_BYTES);

    localparam int ROW_BITS = 32;
    localparam int BIT_W    = $clog2(ROW_BITS);
    localparam int ROWS     = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BLK_W    = $clog2(MAX_BLOCKS);
    localparam int IDX_W    = BLK_W + 1;

    localparam int OP_W     = 2;
    localparam int SIZE_W   = 13;
    localparam int OFF_W    = 12;
    localparam int NEED_W   = SIZE_W - BB_SHIFT + 1;
    localparam int STATUS_W = 2;
    localparam int FRAG_W   = 10;
    localparam int BC_W     = 11;
    localparam int CFG_W    = 11;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 24;

    localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAG  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OFF   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_START = 2'd3;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_POOL_SIZE  = 1'b1;

    localparam logic [BC_W-1:0] POOL_SIZE_RESET = BC_W'(1024);

endpackage

// File: design/bitmap_fit_allocator_unit.sv
`timescale 1ns / 1ps
// Bitmap fit allocator: used and start bitmaps in row memories, one block
// examined per cycle in S_BIT by a shared run counter. Depends on bfa_pkg.
//
// Allocate and fragment query scan the n pool blocks, each row read first
// (S_RD, S_LD); allocate then marks the run one block per cycle within a row,
// writing back each row touched; free walks the allocation the same way; a
// request refused at once goes straight to the result. One item at a time:
// the block walk with its row read and write-back sets the rate. Reset (rst_n,
// async) and a pool-size write clear row valid bits at once; no clearing pass.
module bitmap_fit_allocator_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [bfa_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode[1:0], size_bytes[14:2], offset[26:15], zero [31:27]
    input  logic [bfa_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status[1:0], alloc_offset[13:2], frag_count[23:14]
    output logic [bfa_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_LD   = 3'd2;
    localparam logic [2:0] S_BIT  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_MARK  = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_FRAG  = 2'd3;

    logic [bfa_pkg::ROW_BITS-1:0] used_mem  [bfa_pkg::ROWS];
    logic [bfa_pkg::ROW_BITS-1:0] start_mem [bfa_pkg::ROWS];
    logic [bfa_pkg::ROW_BITS-1:0] rd_used_q;
    logic [bfa_pkg::ROW_BITS-1:0] rd_start_q;
    logic [bfa_pkg::ROW_W-1:0]    rd_row;
    logic                         mem_we;

    logic [2:0]                     state_reg,     state_next;
    logic [1:0]                     mode_reg,      mode_next;
    logic [bfa_pkg::IDX_W-1:0]      idx_reg,       idx_next;
    logic [bfa_pkg::ROW_W-1:0]      cur_row_reg,   cur_row_next;
    logic [bfa_pkg::IDX_W-1:0]      run_reg,       run_next;
    logic [bfa_pkg::BLK_W-1:0]      run_at_reg,    run_at_next;
    logic [bfa_pkg::IDX_W-1:0]      best_reg,      best_next;
    logic [bfa_pkg::BLK_W-1:0]      best_at_reg,   best_at_next;
    logic                           found_reg,     found_next;
    logic [bfa_pkg::NEED_W-1:0]     need_reg,      need_next;
    logic [bfa_pkg::NEED_W-1:0]     left_reg,      left_next;
    logic [bfa_pkg::SIZE_W-1:0]     thresh_reg,    thresh_next;
    logic [bfa_pkg::FRAG_W-1:0]     frag_reg,      frag_next;
    logic                           first_reg,     first_next;
    logic                           dirty_reg,     dirty_next;
    logic                           done_reg,      done_next;
    logic [bfa_pkg::ROW_BITS-1:0]   used_buf_reg,  used_buf_next;
    logic [bfa_pkg::ROW_BITS-1:0]   start_buf_reg, start_buf_next;
    logic [bfa_pkg::ROWS-1:0]       row_valid_reg, row_valid_next;
    logic                           fit_policy_reg, fit_policy_next;
    logic [bfa_pkg::BC_W-1:0]       pool_size_reg, pool_size_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bfa_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [bfa_pkg::OFF_W-1:0]      out_offset_reg, out_offset_next;
    logic [bfa_pkg::FRAG_W-1:0]     out_frag_reg,  out_frag_next;

    logic [bfa_pkg::IDX_W-1:0]      pool_n;
    logic [bfa_pkg::OP_W-1:0]       in_op;
    logic [bfa_pkg::SIZE_W-1:0]     in_size;
    logic [bfa_pkg::OFF_W-1:0]      in_off;
    logic [bfa_pkg::BLK_W-1:0]      in_blk;

    assign in_op   = s_axis_tdata[1:0];
    assign in_size = s_axis_tdata[14:2];
    assign in_off  = s_axis_tdata[26:15];
    assign in_blk  = in_off[bfa_pkg::OFF_W-1:bfa_pkg::BB_SHIFT];

    assign pool_n = (pool_size_reg > bfa_pkg::BC_W'(bfa_pkg::MAX_BLOCKS))
                  ? bfa_pkg::IDX_W'(bfa_pkg::MAX_BLOCKS)
                  : bfa_pkg::IDX_W'(pool_size_reg);

    assign rd_row = idx_reg[bfa_pkg::BLK_W-1:bfa_pkg::BIT_W];
    assign mem_we = (state_reg == S_WR);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_frag_reg, out_offset_reg, out_status_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_mem[cur_row_reg]  <= used_buf_reg;
            start_mem[cur_row_reg] <= start_buf_reg;
        end
        rd_used_q  <= used_mem[rd_row];
        rd_start_q <= start_mem[rd_row];
    end

    always_comb
    begin
        logic [bfa_pkg::BIT_W-1:0]  b;
        logic                       u;
        logic                       s;
        logic                       at_end;
        logic [bfa_pkg::IDX_W-1:0]  idx_inc;
        logic                       adv_end;
        logic                       adv_row;
        logic                       take;
        logic [bfa_pkg::NEED_W-1:0] need_calc;

        state_next       = state_reg;
        mode_next        = mode_reg;
        idx_next         = idx_reg;
        cur_row_next     = cur_row_reg;
        run_next         = run_reg;
        run_at_next      = run_at_reg;
        best_next        = best_reg;
        best_at_next     = best_at_reg;
        found_next       = found_reg;
        need_next        = need_reg;
        left_next        = left_reg;
        thresh_next      = thresh_reg;
        frag_next        = frag_reg;
        first_next       = first_reg;
        dirty_next       = dirty_reg;
        done_next        = done_reg;
        used_buf_next    = used_buf_reg;
        start_buf_next   = start_buf_reg;
        row_valid_next   = row_valid_reg;
        fit_policy_next  = fit_policy_reg;
        pool_size_next   = pool_size_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_offset_next  = out_offset_reg;
        out_frag_next    = out_frag_reg;

        b       = idx_reg[bfa_pkg::BIT_W-1:0];
        u       = used_buf_reg[b];
        s       = start_buf_reg[b];
        at_end  = (idx_reg == pool_n);
        idx_inc = idx_reg + bfa_pkg::IDX_W'(1);
        adv_end = (idx_inc == pool_n);
        adv_row = (idx_inc[bfa_pkg::BIT_W-1:0] == '0);
        need_calc = bfa_pkg::NEED_W'((({1'b0, in_size}
                  + (bfa_pkg::SIZE_W+1)'(bfa_pkg::BLOCK_BYTES - 1)))
                  >> bfa_pkg::BB_SHIFT);
        take = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    out_status_next = bfa_pkg::ST_OK;
                    out_offset_next = '0;
                    out_frag_next   = '0;
                    idx_next        = '0;
                    run_next        = '0;
                    found_next      = 1'b0;
                    frag_next       = '0;
                    dirty_next      = 1'b0;
                    done_next       = 1'b0;
                    thresh_next     = in_size;
                    need_next       = need_calc;
                    unique case (in_op)
                        bfa_pkg::OP_ALLOC:
                        begin
                            if (in_size == '0)
                            begin
                                out_status_next = bfa_pkg::ST_NO_SPACE;
                                out_valid_next  = 1'b1;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                mode_next  = MODE_ALLOC;
                                state_next = (pool_n == '0) ? S_BIT : S_RD;
                            end
                        end
                        bfa_pkg::OP_FREE:
                        begin
                            if ((in_off[bfa_pkg::BB_SHIFT-1:0] != '0) ||
                                ({1'b0, in_blk} >= pool_n))
                            begin
                                out_status_next = bfa_pkg::ST_BAD_OFF;
                                out_valid_next  = 1'b1;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                mode_next  = MODE_FREE;
                                idx_next   = {1'b0, in_blk};
                                first_next = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        bfa_pkg::OP_FRAG:
                        begin
                            mode_next  = MODE_FRAG;
                            state_next = (pool_n == '0) ? S_BIT : S_RD;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cur_row_next = rd_row;
                state_next   = S_LD;
            end
            S_LD:
            begin
                used_buf_next  = row_valid_reg[cur_row_reg] ? rd_used_q  : '0;
                start_buf_next = row_valid_reg[cur_row_reg] ? rd_start_q : '0;
                dirty_next     = 1'b0;
                state_next     = S_BIT;
            end
            S_BIT:
            begin
                case (mode_reg) inside
                    MODE_ALLOC, MODE_FRAG:
                    begin
                        if (at_end || u)
                        begin
                            if (mode_reg == MODE_ALLOC)
                            begin
                                take = (bfa_pkg::NEED_W'(run_reg) >= need_reg) &&
                                       (!found_reg ||
                                        (fit_policy_reg ? (run_reg > best_reg)
                                                        : (run_reg < best_reg)));
                                if (take)
                                begin
                                    best_next    = run_reg;
                                    best_at_next = run_at_reg;
                                    found_next   = 1'b1;
                                end
                            end
                            else if ((run_reg != '0) &&
                                     ({run_reg, {bfa_pkg::BB_SHIFT{1'b0}}} <
                                      (bfa_pkg::IDX_W+bfa_pkg::BB_SHIFT)'(thresh_reg)) &&
                                     (frag_reg != bfa_pkg::FRAG_MAX))
                            begin
                                frag_next = frag_reg + bfa_pkg::FRAG_W'(1);
                            end
                            run_next = '0;
                        end
                        else
                        begin
                            if (run_reg == '0)
                                run_at_next = idx_reg[bfa_pkg::BLK_W-1:0];
                            run_next = run_reg + bfa_pkg::IDX_W'(1);
                        end

                        if (at_end)
                        begin
                            if (mode_reg == MODE_FRAG)
                            begin
                                out_frag_next  = frag_next;
                                out_valid_next = 1'b1;
                                state_next     = S_OUT;
                            end
                            else if (found_next)
                            begin
                                mode_next  = MODE_MARK;
                                idx_next   = bfa_pkg::IDX_W'(best_at_next);
                                left_next  = need_reg;
                                state_next = S_RD;
                            end
                            else
                            begin
                                out_status_next = bfa_pkg::ST_NO_SPACE;
                                out_valid_next  = 1'b1;
                                state_next      = S_OUT;
                            end
                        end
                        else
                        begin
                            idx_next = idx_inc;
                            if (!adv_end && adv_row)
                                state_next = S_RD;
                        end
                    end
                    MODE_MARK:
                    begin
                        used_buf_next[b] = 1'b1;
                        if (idx_reg[bfa_pkg::BLK_W-1:0] == best_at_reg)
                            start_buf_next[b] = 1'b1;
                        dirty_next = 1'b1;
                        left_next  = left_reg - bfa_pkg::NEED_W'(1);
                        idx_next   = idx_inc;
                        if (left_reg == bfa_pkg::NEED_W'(1))
                        begin
                            done_next  = 1'b1;
                            state_next = S_WR;
                        end
                        else if (adv_row)
                        begin
                            state_next = S_WR;
                        end
                    end
                    default:
                    begin
                        if (first_reg && !s)
                        begin
                            out_status_next = bfa_pkg::ST_NOT_START;
                            out_valid_next  = 1'b1;
                            state_next      = S_OUT;
                        end
                        else if (!first_reg && (s || !u))
                        begin
                            done_next = 1'b1;
                            if (dirty_reg)
                            begin
                                state_next = S_WR;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                state_next     = S_OUT;
                            end
                        end
                        else
                        begin
                            used_buf_next[b]  = 1'b0;
                            start_buf_next[b] = 1'b0;
                            first_next        = 1'b0;
                            dirty_next        = 1'b1;
                            idx_next          = idx_inc;
                            if (adv_end)
                            begin
                                done_next  = 1'b1;
                                state_next = S_WR;
                            end
                            else if (adv_row)
                            begin
                                state_next = S_WR;
                            end
                        end
                    end
                endcase
            end
            S_WR:
            begin
                row_valid_next[cur_row_reg] = 1'b1;
                if (done_reg)
                begin
                    if (mode_reg == MODE_MARK)
                        out_offset_next = bfa_pkg::OFF_W'({best_at_reg,
                                          {bfa_pkg::BB_SHIFT{1'b0}}});
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            if (cfg_index == bfa_pkg::REG_FIT_POLICY)
            begin
                fit_policy_next = cfg_data[0];
            end
            else
            begin
                pool_size_next = bfa_pkg::BC_W'(cfg_data);
                row_valid_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= MODE_ALLOC;
            idx_reg         <= '0;
            cur_row_reg     <= '0;
            run_reg         <= '0;
            run_at_reg      <= '0;
            best_reg        <= '0;
            best_at_reg     <= '0;
            found_reg       <= 1'b0;
            need_reg        <= '0;
            left_reg        <= '0;
            thresh_reg      <= '0;
            frag_reg        <= '0;
            first_reg       <= 1'b0;
            dirty_reg       <= 1'b0;
            done_reg        <= 1'b0;
            used_buf_reg    <= '0;
            start_buf_reg   <= '0;
            row_valid_reg   <= '0;
            fit_policy_reg  <= 1'b0;
            pool_size_reg   <= bfa_pkg::POOL_SIZE_RESET;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= bfa_pkg::ST_OK;
            out_offset_reg  <= '0;
            out_frag_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            idx_reg         <= idx_next;
            cur_row_reg     <= cur_row_next;
            run_reg         <= run_next;
            run_at_reg      <= run_at_next;
            best_reg        <= best_next;
            best_at_reg     <= best_at_next;
            found_reg       <= found_next;
            need_reg        <= need_next;
            left_reg        <= left_next;
            thresh_reg      <= thresh_next;
            frag_reg        <= frag_next;
            first_reg       <= first_next;
            dirty_reg       <= dirty_next;
            done_reg        <= done_next;
            used_buf_reg    <= used_buf_next;
            start_buf_reg   <= start_buf_next;
            row_valid_reg   <= row_valid_next;
            fit_policy_reg  <= fit_policy_next;
            pool_size_reg   <= pool_size_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_offset_reg  <= out_offset_next;
            out_frag_reg    <= out_frag_next;
        end
    end

    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> dirty_reg)
        else $error("row write-back without a modified row");

    a_mark_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BIT) && (mode_reg == MODE_MARK)) |-> (idx_reg < pool_n))
        else $error("allocation marks a block beyond the pool");

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD) |-> ($past(state_reg) == S_RD))
        else $error("row load without a preceding read");

endmodule

// File: test/bitmap_fit_allocator_unit_test.sv
`timescale 1ns / 1ps
// Testbench for bitmap_fit_allocator_unit: allocate, free and fragment-count beats
// checked field by field against a bit-level predictor of the used and start maps.
// Depends on bfa_pkg and the design sources.
module bitmap_fit_allocator_unit_test;

    localparam logic [bfa_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int IDLE_PCT      = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic [bfa_pkg::OP_W-1:0]   opcode;
        logic [bfa_pkg::SIZE_W-1:0] size_bytes;
        logic [bfa_pkg::OFF_W-1:0]  offset;
    } pool_request_t;

    typedef struct {
        logic [bfa_pkg::STATUS_W-1:0] status;
        logic [bfa_pkg::OFF_W-1:0]    alloc_offset;
        logic [bfa_pkg::FRAG_W-1:0]   frag_count;
    } pool_reply_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic                      cfg_index     = 1'b0;
    logic [bfa_pkg::CFG_W-1:0] cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [bfa_pkg::IN_W-1:0]  s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [bfa_pkg::OUT_W-1:0] m_axis_tdata;

    bit                       used_blk [bfa_pkg::MAX_BLOCKS];
    bit                       head_blk [bfa_pkg::MAX_BLOCKS];
    bit                       policy_worst = 1'b0;
    logic [bfa_pkg::BC_W-1:0] pool_count   = bfa_pkg::POOL_SIZE_RESET;

    pool_request_t requests_pending [$];
    pool_reply_t   replies_due [$];
    pool_request_t beat_on_bus;
    int            mismatch_count = 0;
    int            replies_seen   = 0;
    int            quiet_cycles   = 0;
    int            hold_left      = 0;
    bit            hold_req       = 1'b0;
    bit            hold_done      = 1'b0;
    bit            no_idle        = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bitmap_fit_allocator_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int live_blocks();
        return (pool_count > bfa_pkg::MAX_BLOCKS) ? bfa_pkg::MAX_BLOCKS : int'(pool_count);
    endfunction

    function automatic pool_reply_t allocator_answer(pool_request_t req);
        pool_reply_t rep;
        int          n;
        int          need;
        int          run;
        int          run_at;
        int          best;
        int          best_at;
        int          blk;
        int          cnt;
        bit          found;
        rep     = '{bfa_pkg::ST_OK, '0, '0};
        n       = live_blocks();
        run     = 0;
        run_at  = 0;
        best    = 0;
        best_at = 0;
        cnt     = 0;
        found   = 1'b0;
        case (req.opcode)
            bfa_pkg::OP_ALLOC:
            begin
                if (req.size_bytes == 0)
                    rep.status = bfa_pkg::ST_NO_SPACE;
                else
                begin
                    need = (int'(req.size_bytes) + bfa_pkg::BLOCK_BYTES - 1)
                           / bfa_pkg::BLOCK_BYTES;
                    for (int i = 0; i <= n; i++)
                    begin
                        if (i < n && !used_blk[i])
                        begin
                            if (run == 0)
                                run_at = i;
                            run++;
                        end
                        else
                        begin
                            if (run >= need &&
                                (!found || (policy_worst ? run > best : run < best)))
                            begin
                                best    = run;
                                best_at = run_at;
                                found   = 1'b1;
                            end
                            run = 0;
                        end
                    end
                    if (!found)
                        rep.status = bfa_pkg::ST_NO_SPACE;
                    else
                    begin
                        head_blk[best_at] = 1'b1;
                        for (int i = 0; i < need; i++)
                            used_blk[best_at + i] = 1'b1;
                        rep.alloc_offset = bfa_pkg::OFF_W'(best_at * bfa_pkg::BLOCK_BYTES);
                    end
                end
            end
            bfa_pkg::OP_FREE:
            begin
                blk = int'(req.offset) / bfa_pkg::BLOCK_BYTES;
                if (int'(req.offset) % bfa_pkg::BLOCK_BYTES != 0 || blk >= n)
                    rep.status = bfa_pkg::ST_BAD_OFF;
                else if (!head_blk[blk])
                    rep.status = bfa_pkg::ST_NOT_START;
                else
                begin
                    head_blk[blk] = 1'b0;
                    used_blk[blk] = 1'b0;
                    for (int i = blk + 1; i < n && !head_blk[i] && used_blk[i]; i++)
                        used_blk[i] = 1'b0;
                end
            end
            bfa_pkg::OP_FRAG:
            begin
                for (int i = 0; i <= n; i++)
                begin
                    if (i < n && !used_blk[i])
                        run++;
                    else
                    begin
                        if (run > 0 && run * bfa_pkg::BLOCK_BYTES < int'(req.size_bytes)
                            && cnt < int'(bfa_pkg::FRAG_MAX))
                            cnt++;
                        run = 0;
                    end
                end
                rep.frag_count = bfa_pkg::FRAG_W'(cnt);
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    function automatic pool_request_t random_request();
        pool_request_t req;
        int            n;
        int            pick;
        int            k;
        int            heads [$];
        n              = live_blocks();
        req.opcode     = OP_SPARE;
        req.size_bytes = bfa_pkg::SIZE_W'($urandom);
        req.offset     = bfa_pkg::OFF_W'($urandom);
        pick           = $urandom_range(0, 99);
        k              = $urandom_range(0, 19);
        if (pick < 45)
        begin
            req.opcode = bfa_pkg::OP_ALLOC;
            if (k < 14)
                req.size_bytes = bfa_pkg::SIZE_W'($urandom_range(1,
                                 bfa_pkg::BLOCK_BYTES * ((n > 7) ? n / 4 : 2)));
            else if (k < 17)
                req.size_bytes = bfa_pkg::SIZE_W'($urandom_range(1,
                                 bfa_pkg::BLOCK_BYTES * n + 8));
            else if (k == 17)
                req.size_bytes = '0;
        end
        else if (pick < 85)
        begin
            req.opcode = bfa_pkg::OP_FREE;
            for (int i = 0; i < n; i++)
                if (head_blk[i])
                    heads.push_back(i);
            if (heads.size() > 0 && k < 14)
                req.offset = bfa_pkg::OFF_W'(heads[$urandom_range(0, heads.size() - 1)]
                             * bfa_pkg::BLOCK_BYTES);
            else if (k < 18)
                req.offset = bfa_pkg::OFF_W'($urandom_range(0, (n > 0) ? n - 1 : 0)
                             * bfa_pkg::BLOCK_BYTES);
        end
        else if (pick < 97)
        begin
            req.opcode = bfa_pkg::OP_FRAG;
            if (k < 16)
                req.size_bytes = bfa_pkg::SIZE_W'($urandom_range(0,
                                 bfa_pkg::BLOCK_BYTES * n + 8));
        end
        return req;
    endfunction

    function automatic void queue_request(logic [bfa_pkg::OP_W-1:0] op, int size, int off);
        requests_pending.push_back(pool_request_t'{op, bfa_pkg::SIZE_W'(size),
                                                   bfa_pkg::OFF_W'(off)});
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] result %0d: %s", $realtime, replies_seen, what);
        mismatch_count++;
    endtask

    task automatic write_reg(logic idx, logic [bfa_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == bfa_pkg::REG_FIT_POLICY)
            policy_worst = val[0];
        else
        begin
            pool_count = val[bfa_pkg::BC_W-1:0];
            used_blk   = '{default: 1'b0};
            head_blk   = '{default: 1'b0};
        end
    endtask

    task automatic set_pool(bit policy, int count);
        logic [bfa_pkg::CFG_W-1:0] pol_val;
        pol_val    = bfa_pkg::CFG_W'($urandom);
        pol_val[0] = policy;
        write_reg(bfa_pkg::REG_FIT_POLICY, pol_val);
        write_reg(bfa_pkg::REG_POOL_SIZE, bfa_pkg::CFG_W'(count));
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (requests_pending.size() > 0 || s_axis_tvalid || replies_due.size() > 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(bit policy, int count, int total);
        int made;
        made = 0;
        set_pool(policy, count);
        while (made < total)
        begin
            @(negedge clk);
            if (requests_pending.size() < 2)
            begin
                requests_pending.push_back(random_request());
                made++;
            end
        end
        drain();
    endtask

    // drive request beats, predict each one as it is accepted
    always @(posedge clk)
    begin : drive_requests
        bit take;
        bit give;
        if (rst_n)
        begin
            take = s_axis_tvalid && s_axis_tready;
            if (take)
                replies_due.push_back(allocator_answer(beat_on_bus));
            if (!s_axis_tvalid || take)
            begin
                give = requests_pending.size() > 0
                       && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
                if (give)
                begin
                    beat_on_bus  = requests_pending.pop_front();
                    s_axis_tdata <= bfa_pkg::IN_W'({beat_on_bus.offset,
                                                    beat_on_bus.size_bytes,
                                                    beat_on_bus.opcode});
                end
                s_axis_tvalid <= give;
            end
        end
    end

    always @(posedge clk)
    begin : watch_results
        pool_reply_t want;
        bit          rdy;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch($sformatf("result beat %h with nothing pending",
                                              m_axis_tdata));
                else
                begin
                    want = replies_due.pop_front();
                    if (m_axis_tdata[bfa_pkg::STATUS_W-1:0] !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                        m_axis_tdata[bfa_pkg::STATUS_W-1:0], want.status));
                    if (m_axis_tdata[bfa_pkg::STATUS_W+bfa_pkg::OFF_W-1:bfa_pkg::STATUS_W]
                        !== want.alloc_offset)
                        report_mismatch($sformatf("alloc_offset %0d, predicted %0d",
                            m_axis_tdata[bfa_pkg::STATUS_W+bfa_pkg::OFF_W-1:bfa_pkg::STATUS_W],
                            want.alloc_offset));
                    if (m_axis_tdata[bfa_pkg::OUT_W-1:bfa_pkg::STATUS_W+bfa_pkg::OFF_W]
                        !== want.frag_count)
                        report_mismatch($sformatf("frag_count %0d, predicted %0d",
                            m_axis_tdata[bfa_pkg::OUT_W-1:bfa_pkg::STATUS_W+bfa_pkg::OFF_W],
                            want.frag_count));
                end
                replies_seen++;
            end
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
                rdy = no_idle || $urandom_range(0, 99) >= IDLE_PCT;
            m_axis_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("bitmap_fit_allocator_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: best fit over the full pool
        queue_request(bfa_pkg::OP_ALLOC, 0, 4095);
        queue_request(bfa_pkg::OP_ALLOC, 1, 0);
        queue_request(bfa_pkg::OP_ALLOC, 4096, 0);
        queue_request(bfa_pkg::OP_ALLOC, 8, 0);
        queue_request(bfa_pkg::OP_ALLOC, 13, 0);
        queue_request(bfa_pkg::OP_ALLOC, 5, 0);
        queue_request(bfa_pkg::OP_FREE, 8191, 4);
        queue_request(bfa_pkg::OP_FREE, 0, 4);
        queue_request(bfa_pkg::OP_FREE, 0, 6);
        queue_request(bfa_pkg::OP_FREE, 0, 4092);
        queue_request(bfa_pkg::OP_ALLOC, 4, 0);
        queue_request(bfa_pkg::OP_FRAG, 8, 0);
        queue_request(bfa_pkg::OP_FRAG, 8191, 0);
        queue_request(OP_SPARE, 8191, 4095);
        queue_request(bfa_pkg::OP_FREE, 0, 12);
        drain();

        // worst fit picks the largest hole
        set_pool(1'b1, 16);
        queue_request(bfa_pkg::OP_ALLOC, 8, 0);
        queue_request(bfa_pkg::OP_ALLOC, 4, 0);
        queue_request(bfa_pkg::OP_FREE, 0, 0);
        queue_request(bfa_pkg::OP_ALLOC, 4, 0);
        drain();

        // empty pool
        set_pool(1'b0, 0);
        queue_request(bfa_pkg::OP_ALLOC, 4, 0);
        queue_request(bfa_pkg::OP_FREE, 0, 0);
        queue_request(bfa_pkg::OP_FRAG, 100, 0);
        drain();

        // oversized block count clamps to the full pool
        set_pool(1'b1, 2047);
        queue_request(bfa_pkg::OP_ALLOC, 4096, 0);
        queue_request(bfa_pkg::OP_FREE, 0, 4092);
        queue_request(bfa_pkg::OP_FRAG, 8191, 0);
        queue_request(bfa_pkg::OP_FREE, 0, 0);
        drain();

        run_random(1'b0, 1, 30);
        run_random(1'b1, 8, 60);
        run_random(1'b0, 24, 70);
        no_idle = 1'b1;
        run_random(1'b1, 64, 80);
        no_idle  = 1'b0;
        hold_req = 1'b1;
        run_random(1'b0, 37, 80);
        run_random(1'b1, 200, 50);
        run_random(1'b0, 1024, 40);
        run_random(1'b1, 2047, 30);
        run_random(1'b1, 13, 60);
        run_random(1'b0, 5, 40);
        run_random(1'b1, 3, 20);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("bitmap_fit_allocator_unit: match");
        else
            $display("bitmap_fit_allocator_unit: mismatch");
        $finish;
    end

endmodule

// File: bitmap_fit_allocator_unit.f
design/bfa_pkg.sv
design/bitmap_fit_allocator_unit.sv
test/bitmap_fit_allocator_unit_test.sv
